FILE: design/dehr_pkg.sv
// Shared types and constants for the duplicate-suppressing event log.
`timescale 1ns / 1ps
package dehr_pkg;

   // Command codes carried in the request transaction.
   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_WIPE   = 2'd2;
   localparam logic [1:0] CMD_NOP    = 2'd3;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXEMPT_TYPE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEDUP_WINDOW = 2'd1;
   localparam int CSR_DATA_W = 16;

   localparam logic [7:0]  EXEMPT_TYPE_RESET  = 8'd0;
   localparam logic [15:0] DEDUP_WINDOW_RESET = 16'd120;

   localparam int ENTRY_W = 120;
   localparam int COUNT_OUT_W = 7;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] now_seconds;
      logic [31:0] cumulative_amount;
      logic [7:0]  event_type;
      logic [7:0]  profile_id;
      logic [7:0]  loop_mode_code;
      logic [15:0] temp_percent;
      logic [15:0] rate_value;
      logic [5:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        stored;
      logic        read_valid;
      logic [31:0] entry_time;
      logic [31:0] entry_amount;
      logic [7:0]  entry_type;
      logic [7:0]  entry_profile;
      logic [7:0]  entry_mode;
      logic [15:0] entry_percent;
      logic [15:0] entry_rate;
      logic [6:0]  entry_count;
   } rsp_type;

   // One stored log record, 120 bits.
   typedef struct packed {
      logic [31:0] stamp;
      logic [31:0] amount;
      logic [7:0]  kind;
      logic [7:0]  profile;
      logic [7:0]  mode;
      logic [15:0] percent;
      logic [15:0] rate;
   } log_entry_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic accept;
      logic finish;
   } ctl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
   } ctl_status_type;

endpackage

FILE: design/dehr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dehr_ram #(
   parameter int WIDTH = 120,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/dehr_ctrl.sv
// Controller state machine: accepts a request, waits in the lookup state until the result register is free, retires it.
`timescale 1ns / 1ps
module dehr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dehr_pkg::ctl_status_type ctl_status,
   output dehr_pkg::ctl_cmd_type    ctl_cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      ctl_cmd.accept = 1'b0;
      ctl_cmd.finish = 1'b0;
      state_in       = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl_cmd.accept = 1'b1;
               state_in       = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // Retire only when the result register can take the new transaction.
            if (ctl_status.out_free) begin
               ctl_cmd.finish = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/dehr_datapath.sv
// Datapath: request holding, ring pointers, duplicate check, settings and result register.
`timescale 1ns / 1ps
module dehr_datapath #(
   parameter int LOG_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dehr_pkg::ctl_cmd_type                ctl_cmd,
   output dehr_pkg::ctl_status_type             ctl_status,
   input  dehr_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dehr_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_valid,
   input  logic [dehr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dehr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 mem_rd_en,
   output logic [$clog2(LOG_DEPTH)-1:0]         mem_rd_addr,
   input  logic [dehr_pkg::ENTRY_W-1:0]         mem_rd_data,
   output logic                                 mem_wr_en,
   output logic [$clog2(LOG_DEPTH)-1:0]         mem_wr_addr,
   output logic [dehr_pkg::ENTRY_W-1:0]         mem_wr_data
);

   localparam int PTR_W = $clog2(LOG_DEPTH);
   localparam int CNT_W = $clog2(LOG_DEPTH + 1);
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
   localparam int SUM_W = $clog2(2 * LOG_DEPTH + 64) + 1;

   dehr_pkg::req_type       req_ff;
   dehr_pkg::rsp_type       rsp_ff;
   dehr_pkg::rsp_type       rsp_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [PTR_W-1:0]        wp_ff;
   logic [PTR_W-1:0]        wp_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;
   logic [7:0]              exempt_ff;
   logic [15:0]             window_ff;

   logic [5:0]              back;
   logic [SUM_W-1:0]        slot_sum;
   logic [PTR_W-1:0]        slot;
   dehr_pkg::log_entry_type last;
   dehr_pkg::log_entry_type new_entry;
   logic [31:0]             elapsed;
   logic                    same_fields;
   logic                    is_dup;
   logic                    is_record;
   logic                    is_read;
   logic                    is_wipe;
   logic                    do_store;
   logic                    read_ok;

   // Lookup address: the newest entry for a record, read_index back for a read.
   always_comb begin
      back     = (req_payload.command == dehr_pkg::CMD_READ) ? req_payload.read_index : 6'd0;
      slot_sum = SUM_W'(wp_ff) + SUM_W'(LOG_DEPTH - 1) - SUM_W'(back);
      if (slot_sum >= SUM_W'(LOG_DEPTH)) begin
         slot = PTR_W'(slot_sum - SUM_W'(LOG_DEPTH));
      end else begin
         slot = PTR_W'(slot_sum);
      end
   end

   assign mem_rd_en   = ctl_cmd.accept;
   assign mem_rd_addr = slot;

   always_comb begin
      last      = dehr_pkg::log_entry_type'(mem_rd_data);
      is_record = (req_ff.command == dehr_pkg::CMD_RECORD);
      is_read   = (req_ff.command == dehr_pkg::CMD_READ);
      is_wipe   = (req_ff.command == dehr_pkg::CMD_WIPE);

      new_entry.stamp   = req_ff.now_seconds;
      new_entry.amount  = req_ff.cumulative_amount;
      new_entry.kind    = req_ff.event_type;
      new_entry.profile = req_ff.profile_id;
      new_entry.mode    = req_ff.loop_mode_code;
      new_entry.percent = req_ff.temp_percent;
      new_entry.rate    = req_ff.rate_value;

      same_fields = (last.kind == new_entry.kind) && (last.profile == new_entry.profile) &&
                    (last.mode == new_entry.mode) && (last.percent == new_entry.percent) &&
                    (last.rate == new_entry.rate);
      // Time running backwards counts as no time elapsed.
      elapsed = (new_entry.stamp >= last.stamp) ? (new_entry.stamp - last.stamp) : 32'd0;
      is_dup  = (cnt_ff != '0) && (new_entry.kind != exempt_ff) && same_fields &&
                (elapsed < {16'd0, window_ff});

      do_store = is_record && !is_dup;
      read_ok  = is_read && (CMP_W'(req_ff.read_index) < CMP_W'(cnt_ff));

      wp_in  = wp_ff;
      cnt_in = cnt_ff;
      if (do_store) begin
         wp_in = (wp_ff == PTR_W'(LOG_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         if (cnt_ff != CNT_W'(LOG_DEPTH)) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (is_wipe) begin
         wp_in  = '0;
         cnt_in = '0;
      end

      rsp_in               = '0;
      rsp_in.stored        = do_store;
      rsp_in.read_valid    = read_ok;
      if (read_ok) begin
         rsp_in.entry_time    = last.stamp;
         rsp_in.entry_amount  = last.amount;
         rsp_in.entry_type    = last.kind;
         rsp_in.entry_profile = last.profile;
         rsp_in.entry_mode    = last.mode;
         rsp_in.entry_percent = last.percent;
         rsp_in.entry_rate    = last.rate;
      end
      rsp_in.entry_count   = dehr_pkg::COUNT_OUT_W'(cnt_in);
   end

   assign mem_wr_en   = ctl_cmd.finish && do_store;
   assign mem_wr_addr = wp_ff;
   assign mem_wr_data = new_entry;

   assign ctl_status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in        = ctl_cmd.finish || (rsp_valid_ff && rsp_stall);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload         = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         exempt_ff    <= dehr_pkg::EXEMPT_TYPE_RESET;
         window_ff    <= dehr_pkg::DEDUP_WINDOW_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctl_cmd.finish) begin
            wp_ff  <= wp_in;
            cnt_ff <= cnt_in;
         end
         if (csr_valid) begin
            if (csr_index == dehr_pkg::CSR_EXEMPT_TYPE) begin
               exempt_ff <= csr_wdata[7:0];
            end else if (csr_index == dehr_pkg::CSR_DEDUP_WINDOW) begin
               window_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.accept) begin
         req_ff <= req_payload;
      end
      if (ctl_cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: design/dedup_event_history_ring_core.sv
// Top level of the duplicate-suppressing circular event log.
// Flow: a request transaction is accepted and the ring memory read is issued; the registered
// read data feeds the duplicate check, and the response transaction is registered when the
// result register is free. A new transaction is not accepted until the current one retires;
// the registered memory read precedes the duplicate check and the write of the new record.
// Reset (synchronous, active high) empties the log and restores the default settings.
`timescale 1ns / 1ps
module dedup_event_history_ring_core #(
   parameter int LOG_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dehr_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dehr_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dehr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dehr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PTR_W = $clog2(LOG_DEPTH);

   // Command and status between the controller and the datapath.
   dehr_pkg::ctl_cmd_type    ctl_cmd;
   dehr_pkg::ctl_status_type ctl_status;

   // Ring memory ports. The memory contents are not cleared; the entry count
   // guarantees that only written entries are ever returned.
   logic                         mem_rd_en;
   logic [PTR_W-1:0]             mem_rd_addr;
   logic [dehr_pkg::ENTRY_W-1:0] mem_rd_data;
   logic                         mem_wr_en;
   logic [PTR_W-1:0]             mem_wr_addr;
   logic [dehr_pkg::ENTRY_W-1:0] mem_wr_data;

   // Settings are plain registers, so a write is always taken at once.
   assign csr_ready = 1'b1;

   dehr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .ctl_status (ctl_status),
      .ctl_cmd    (ctl_cmd)
   );

   dehr_datapath #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl_cmd     (ctl_cmd),
      .ctl_status  (ctl_status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // The ring of records, one entry per logged event.
   dehr_ram #(
      .WIDTH (dehr_pkg::ENTRY_W),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
